### rtl/wildcard_byte_pattern_search_defines.svh
// Assertion macros for the checker file of the pattern search block.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define WBPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbps: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define WBPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbps: next-cycle check failed");

`endif

### rtl/wbps_pkg.sv
// Shared constants, types and register codes of the wildcard byte pattern search.
package wbps_pkg;

    localparam int PATTERN_BYTES  = 16;
    localparam int OFFSET_BITS    = 16;
    localparam int LEN_CAP        = (PATTERN_BYTES < 16) ? PATTERN_BYTES : 16;
    localparam int LEN_W          = 5;
    localparam int PAT_IDX_W      = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1;
    localparam int MATCH_OFFSET_W = 16;
    localparam int CFG_DATA_W     = 64;

    typedef logic [7:0] t_byte;

    typedef enum logic [1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_WILDCARD_MASK  = 2'd2,
        CFG_PATTERN_LENGTH = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    typedef struct packed {
        logic  in_use;
        logic  wild;
        t_byte pat;
    } t_cell_cfg;

endpackage

### rtl/wbps_cell.sv
// One window cell: holds a byte and its valid flag and compares the incoming byte.
module wbps_cell
    import wbps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_cell_cfg  i_cfg,
    input  logic       i_valid,
    input  t_byte      i_byte,
    output logic       o_valid,
    output t_byte      o_byte,
    output logic       o_hit
);

    logic  r_valid;
    t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_byte <= i_byte;
        end
    end

    // The compare looks at the byte this cell holds after the shift.
    assign o_hit   = !i_cfg.in_use || (i_valid && (i_cfg.wild || (i_byte == i_cfg.pat)));
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

### rtl/wildcard_byte_pattern_search.sv
// Top level of the wildcard byte pattern search: config, cell chain, match tracking, output.
//
// The block scans a buffer one byte per transfer on the input channel
// (i_in_valid, o_in_ready, i_data_byte, i_last_byte) against a pattern of up
// to 16 bytes with per-byte wildcards, set through the configuration channel
// (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data), which is always ready.
// The user must write configuration only while no buffer is in progress; the
// block does not enforce this. It takes one byte per cycle while o_in_ready
// is high: a chain of cells shifts the window and all cells compare in
// parallel in the cycle the byte is accepted. Only the byte marked last
// produces a result: one transfer on the output channel (o_out_valid,
// i_out_ready, o_found, o_match_offset), registered in the output register,
// or in the skid register while an earlier result waits. o_match_offset is
// the start offset of the first full match, or 0 when nothing matched. The
// window, position and match latch clear after the last byte. An output
// register and a one-entry skid register hold up to two results; input is
// stalled only while both are full, so a stalled receiver costs no throughput
// until a second result is waiting. Reset (synchronous, active low) clears
// valid flags and match tracking, the pattern to zero and the length to one.
module wildcard_byte_pattern_search
    import wbps_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_last_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_found,
    output logic [MATCH_OFFSET_W-1:0] o_match_offset,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    logic [63:0]      r_pattern_low;
    logic [63:0]      r_pattern_high;
    logic [15:0]      r_wildcard_mask;
    logic [LEN_W-1:0] r_pattern_length;

    logic                   r_seen;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [OFFSET_BITS-1:0] r_first;

    logic                      r_out_valid;
    logic                      r_out_found;
    logic [MATCH_OFFSET_W-1:0] r_out_offset;
    logic                      r_skid_valid;
    logic                      r_skid_found;
    logic [MATCH_OFFSET_W-1:0] r_skid_offset;

    logic                   w_accept;
    logic                   w_push;
    logic                   w_take;
    logic [LEN_W-1:0]       w_len;
    logic [127:0]           w_pattern;
    t_byte                  w_pat [LEN_CAP];
    t_cell_ctrl             w_ctrl;
    t_cell_cfg              w_cfg   [PATTERN_BYTES];
    logic                   w_valid [PATTERN_BYTES];
    t_byte                  w_byte  [PATTERN_BYTES];
    logic [PATTERN_BYTES-1:0] w_hit;
    logic                   w_match;
    logic [OFFSET_BITS:0]   w_pos_p1;
    logic [OFFSET_BITS:0]   w_len_ext;
    logic [OFFSET_BITS-1:0] w_new_first;
    logic                   n_seen;
    logic [OFFSET_BITS-1:0] n_first;
    logic [31:0]            w_first_ext;
    logic                   w_res_found;
    logic [MATCH_OFFSET_W-1:0] w_res_offset;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_wildcard_mask  <= '0;
            r_pattern_length <= LEN_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PATTERN_LOW:    r_pattern_low    <= i_cfg_data[63:0];
                CFG_PATTERN_HIGH:   r_pattern_high   <= i_cfg_data[63:0];
                CFG_WILDCARD_MASK:  r_wildcard_mask  <= i_cfg_data[15:0];
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_len     = (r_pattern_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : r_pattern_length;
    assign w_pattern = {r_pattern_high, r_pattern_low};

    assign o_in_ready = !r_skid_valid;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_push     = w_accept && i_last_byte;
    assign w_take     = r_out_valid && i_out_ready;

    assign w_ctrl.shift = w_accept;
    assign w_ctrl.clear = w_push;

    genvar gi;
    generate
        for (gi = 0; gi < LEN_CAP; gi++) begin : g_pat
            assign w_pat[gi] = w_pattern[8*gi +: 8];
        end

        for (gi = 0; gi < PATTERN_BYTES; gi++) begin : g_cell
            logic [PAT_IDX_W-1:0] w_pidx;
            logic                 w_in_valid;
            t_byte                w_in_byte;

            assign w_pidx            = PAT_IDX_W'(int'(w_len) - gi - 1);
            assign w_cfg[gi].in_use  = (int'(w_len) > gi);
            assign w_cfg[gi].wild    = r_wildcard_mask[w_pidx];
            assign w_cfg[gi].pat     = w_pat[w_pidx];

            if (gi == 0) begin : g_head
                assign w_in_valid = 1'b1;
                assign w_in_byte  = i_data_byte;
            end else begin : g_body
                assign w_in_valid = w_valid[gi-1];
                assign w_in_byte  = w_byte[gi-1];
            end

            wbps_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_cfg   (w_cfg[gi]),
                .i_valid (w_in_valid),
                .i_byte  (w_in_byte),
                .o_valid (w_valid[gi]),
                .o_byte  (w_byte[gi]),
                .o_hit   (w_hit[gi])
            );
        end
    endgenerate

    assign w_match   = (w_len != '0) && (&w_hit);
    assign w_pos_p1  = {1'b0, r_pos} + (OFFSET_BITS+1)'(1);
    assign w_len_ext = (OFFSET_BITS+1)'(w_len);

    always_comb begin
        w_new_first = OFF_MAX;
        if (r_pos != OFF_MAX && w_pos_p1 >= w_len_ext) begin
            w_new_first = OFFSET_BITS'(w_pos_p1 - w_len_ext);
        end
        n_seen  = r_seen;
        n_first = r_first;
        if (!r_seen && w_match) begin
            n_seen  = 1'b1;
            n_first = w_new_first;
        end
    end

    assign w_first_ext  = 32'(n_first);
    assign w_res_found  = n_seen;
    assign w_res_offset = !n_seen ? '0 :
                          (w_first_ext > 32'(16'hFFFF)) ? MATCH_OFFSET_W'(16'hFFFF) :
                          MATCH_OFFSET_W'(w_first_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_pos   <= '0;
            r_first <= '0;
        end else if (w_push) begin
            r_seen  <= 1'b0;
            r_pos   <= '0;
            r_first <= '0;
        end else if (w_accept) begin
            r_seen  <= n_seen;
            r_first <= n_first;
            if (r_pos != OFF_MAX) begin
                r_pos <= r_pos + OFFSET_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_out_found  <= r_skid_found;
                r_out_offset <= r_skid_offset;
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_take) begin
                r_out_valid  <= 1'b1;
                r_out_found  <= w_res_found;
                r_out_offset <= w_res_offset;
            end else begin
                r_skid_valid  <= 1'b1;
                r_skid_found  <= w_res_found;
                r_skid_offset <= w_res_offset;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_match_offset = r_out_offset;

endmodule

### rtl/wbps_checker.sv
// Port-level checker for the wildcard byte pattern search, bound to the top level.
`include "wildcard_byte_pattern_search_defines.svh"

module wbps_checker
    import wbps_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic [7:0]                i_data_byte,
    input logic                      i_last_byte,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic                      o_found,
    input logic [MATCH_OFFSET_W-1:0] o_match_offset,
    input logic                      i_cfg_valid,
    input logic                      o_cfg_ready,
    input logic [1:0]                i_cfg_index,
    input logic [CFG_DATA_W-1:0]     i_cfg_data
);

    `WBPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_found) && $stable(o_match_offset))

    `WBPS_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, i_in_valid && o_in_ready && i_last_byte, o_out_valid)

    `WBPS_ASSERT_NOW(a_stall_needs_result, i_clk, i_rst_n, !o_in_ready, o_out_valid)

    `WBPS_ASSERT_NOW(a_no_match_zero_offset, i_clk, i_rst_n, o_out_valid && !o_found, o_match_offset == '0)

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (.*);
